@@ rtl/tlf_pkg.sv @@
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants of the text line folder
// Hold store depth, register indexes, control and status structs.
// ----------------------------------------------------------------------------
package tlf_pkg;

  localparam int HOLD_DEPTH = 62;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int COL_W      = 17;
  localparam int WIDTH_W    = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_AT_SPACE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_BYTES    = 2'd2;

  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 16'd80;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NL_PRE,
    S_RD,
    S_FLUSH,
    S_NL_POST,
    S_BYTE
  } state_t;

  typedef enum logic [1:0] {
    SEL_NL,
    SEL_HOLD,
    SEL_BYTE
  } sel_t;

  // datapath -> controller
  typedef struct packed {
    logic held_only;   // byte goes to the hold store, no beat
    logic nl_pre;      // newline before the held bytes
    logic nl_post;     // newline after the held bytes
    logic flush;       // held bytes to emit
    logic flush_last;  // current flush entry is the final one
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic ram_re;
    logic rd_next;
    sel_t sel;
  } cmd_t;

endpackage

@@ rtl/tlf_ram.sv @@
// ----------------------------------------------------------------------------
// tlf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ rtl/tlf_datapath.sv @@
// ----------------------------------------------------------------------------
// tlf_datapath: column tracking, hold store and result selection
// Decides the plan of each byte, keeps line state and config registers.
// ----------------------------------------------------------------------------
module tlf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlf_pkg::WIDTH_W-1:0]    cfg_data,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_end_of_line,
  input  tlf_pkg::cmd_t                  cmd,
  output tlf_pkg::status_t               status,
  output logic [7:0]                     out_byte,
  output logic                           out_hold_overflow
);
  import tlf_pkg::*;

  logic [WIDTH_W-1:0] line_width_r;
  logic               break_at_space_r;
  logic               count_bytes_r;

  logic [COL_W-1:0]   column_r, column_nxt;
  logic               spv_r, spv_nxt;
  logic [CNT_W-1:0]   hold_count_r, hold_count_nxt;
  logic               ovf_seen_r, ovf_seen_nxt;

  logic [7:0]         byte_r;
  logic               ovf_flag_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic [CNT_W-1:0]   flush_len_r;
  logic [7:0]         ram_rdata;

  logic               counted, brk, spv_a, is_space, is_ctrl;
  logic               held_cand, ovf, held, held_only;
  logic [COL_W-1:0]   col_a, col_b;
  logic               ram_we;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r     <= LINE_WIDTH_RST;
      break_at_space_r <= 1'b0;
      count_bytes_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_WIDTH:     line_width_r     <= cfg_data;
        REG_BREAK_AT_SPACE: break_at_space_r <= cfg_data[0];
        REG_COUNT_BYTES:    count_bytes_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-byte plan
  always_comb begin
    counted  = count_bytes_r || (in_text_byte[7:6] != 2'b10);
    brk      = counted && (column_r >= {1'b0, line_width_r}) && (column_r != '0);
    spv_a    = brk ? 1'b0 : spv_r;
    col_a    = brk ? '0 : column_r;
    is_space = counted && break_at_space_r &&
               (in_text_byte inside {CH_SPACE, [CH_TAB:CH_CR]});
    is_ctrl  = !count_bytes_r && ((in_text_byte < CH_SPACE) || (in_text_byte == CH_DEL));

    col_b = col_a;
    if (counted) begin
      if (is_ctrl) begin
        case (in_text_byte)
          CH_BS:   col_b = (col_a != '0) ? col_a - COL_W'(1) : col_a;
          CH_CR:   col_b = '0;
          CH_TAB:  col_b = col_a + COL_W'(col_a[2:0] + 3'd1);
          default: col_b = col_a;
        endcase
      end else begin
        col_b = col_a + COL_W'(1);
      end
    end

    held_cand = !is_space && spv_a;
    ovf       = held_cand && (hold_count_r >= CNT_W'(HOLD_DEPTH));
    held      = held_cand && !ovf;
    held_only = held && !in_end_of_line;

    column_nxt     = in_end_of_line ? '0 : col_b;
    spv_nxt        = in_end_of_line ? 1'b0 : (is_space ? 1'b1 : (ovf ? 1'b0 : spv_a));
    hold_count_nxt = held_only ? hold_count_r + CNT_W'(1) : '0;
    ovf_seen_nxt   = in_end_of_line ? 1'b0 : (ovf_seen_r || ovf);
    ram_we         = cmd.accept && held_only;
  end

  assign status.held_only  = held_only;
  assign status.nl_pre     = brk && break_at_space_r && spv_r;
  assign status.nl_post    = brk && !(break_at_space_r && spv_r);
  assign status.flush      = (hold_count_r != '0) && !held_only;
  assign status.flush_last = (rd_idx_r == flush_len_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      spv_r        <= 1'b0;
      hold_count_r <= '0;
      ovf_seen_r   <= 1'b0;
    end else if (cmd.accept) begin
      column_r     <= column_nxt;
      spv_r        <= spv_nxt;
      hold_count_r <= hold_count_nxt;
      ovf_seen_r   <= ovf_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r      <= in_text_byte;
      ovf_flag_r  <= ovf_seen_r || ovf;
      flush_len_r <= hold_count_r;
      rd_idx_r    <= '0;
    end else if (cmd.rd_next) begin
      rd_idx_r <= rd_idx_r + CNT_W'(1);
    end
  end

  tlf_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_hold (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hold_count_r[IDX_W-1:0]),
    .wdata (in_text_byte),
    .re    (cmd.ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (cmd.sel)
      SEL_NL:   out_byte = CH_NL;
      SEL_HOLD: out_byte = ram_rdata;
      SEL_BYTE: out_byte = byte_r;
      default:  out_byte = byte_r;
    endcase
  end

  assign out_hold_overflow = ovf_flag_r;

  a_hold_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_count_r != '0) |-> spv_r)
    else $error("held bytes without a space point");

  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hold_count_r <= CNT_W'(HOLD_DEPTH))
    else $error("hold count beyond store depth");

  a_flush_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_next |-> (rd_idx_r < flush_len_r))
    else $error("flush read past held bytes");

endmodule

@@ rtl/tlf_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlf_ctrl: sequencing controller of the text line folder
// Walks each byte's plan: newline, held-byte flush, newline, byte.
// ----------------------------------------------------------------------------
module tlf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last_of_run,
  input  tlf_pkg::status_t   status,
  output tlf_pkg::cmd_t      cmd
);
  import tlf_pkg::*;

  state_t state_r, state_nxt, start_st;
  logic   flush_r, nl_post_r;

  always_comb begin
    if (status.held_only) begin
      start_st = S_IDLE;
    end else if (status.nl_pre) begin
      start_st = S_NL_PRE;
    end else if (status.flush) begin
      start_st = S_RD;
    end else if (status.nl_post) begin
      start_st = S_NL_POST;
    end else begin
      start_st = S_BYTE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = start_st;
      end
      S_NL_PRE: begin
        if (out_ready) state_nxt = flush_r ? S_RD : S_BYTE;
      end
      S_RD: begin
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (out_ready) begin
          if (!status.flush_last) state_nxt = S_RD;
          else                    state_nxt = nl_post_r ? S_NL_POST : S_BYTE;
        end
      end
      S_NL_POST: begin
        if (out_ready) state_nxt = S_BYTE;
      end
      S_BYTE: begin
        if (out_ready) state_nxt = in_valid ? start_st : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    out_last_of_run = 1'b0;
    cmd.ram_re      = 1'b0;
    cmd.rd_next     = 1'b0;
    cmd.sel         = SEL_BYTE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_NL_PRE, S_NL_POST: begin
        out_valid = 1'b1;
        cmd.sel   = SEL_NL;
      end
      S_RD: begin
        cmd.ram_re = 1'b1;
      end
      S_FLUSH: begin
        out_valid   = 1'b1;
        cmd.sel     = SEL_HOLD;
        cmd.rd_next = out_ready;
      end
      S_BYTE: begin
        out_valid       = 1'b1;
        out_last_of_run = 1'b1;
        in_ready        = out_ready;
      end
      default: ;
    endcase
    cmd.accept = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      flush_r   <= status.flush;
      nl_post_r <= status.nl_post;
    end
  end

  a_rd_then_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_FLUSH))
    else $error("read not followed by flush beat");

  a_accept_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (state_r == S_IDLE || (out_valid && out_last_of_run && out_ready)))
    else $error("byte taken while a run is pending");

  a_nl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(status.nl_pre && status.nl_post))
    else $error("newline planned twice");

endmodule

@@ rtl/text_line_folder_core.sv @@
// ----------------------------------------------------------------------------
// text_line_folder_core: fold a text byte stream to a configured line width
// Inserts newlines by column count, optionally moving breaks after spaces.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_*: one text byte per beat plus an end-of-line flag.
//   Result channel out_*: zero or more beats per input byte; out_last_of_run
//   marks the final beat caused by that byte, out_hold_overflow reports a
//   hold store overflow on the current line.
//   Config channel cfg_*: index 0 line width, 1 break at space, 2 count bytes.
//   Always ready; write only while no results are pending.
// Throughput and beat order
//   The first beat of a byte is offered the cycle after it is accepted, unless
//   it opens with a flush of held bytes, which first passes through S_RD.
//   Plain text runs at one byte per cycle while out_ready is high; a byte
//   that is only held yields no beat. An inserted newline adds a beat;
//   each flushed held byte passes S_RD, the registered RAM read, and S_FLUSH.
// Reset
//   rst_n (synchronous) clears line state and loads width 80, modes off.
// Stalls
//   A stalled out_ready holds the current beat; input is taken only with
//   the last beat of the previous byte or when nothing is pending.
// ----------------------------------------------------------------------------
module text_line_folder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_end_of_line,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_run,
  output logic                           out_hold_overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlf_pkg::WIDTH_W-1:0]    cfg_data
);
  import tlf_pkg::*;

  status_t status;
  cmd_t    cmd;

  assign cfg_ready = 1'b1;

  tlf_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_last_of_run (out_last_of_run),
    .status          (status),
    .cmd             (cmd)
  );

  tlf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_text_byte      (in_text_byte),
    .in_end_of_line    (in_end_of_line),
    .cmd               (cmd),
    .status            (status),
    .out_byte          (out_byte),
    .out_hold_overflow (out_hold_overflow)
  );

endmodule
